// File: hw/rtl/rc4hpd_pkg.sv
// rc4hpd_pkg: shared types and constants for the RC4 header packet deframer.
// No dependencies; imported by rc4_header_packet_deframer_top.
package rc4hpd_pkg;

    // Result transaction kinds
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_LOW   = 2'd0;
    localparam logic [1:0] CFG_KEY_MID   = 2'd1;
    localparam logic [1:0] CFG_KEY_HIGH  = 2'd2;
    localparam logic [1:0] CFG_DIRECTION = 2'd3;

    // Input op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic [4:0]  KEY_LAST      = 5'd19;   // 20-byte key
    localparam logic [1:0]  PLAIN_HEADERS = 2'd2;    // plain headers per session
    localparam logic [1:0]  PLAIN_RESET   = 2'd2;    // plain headers after reset
    localparam logic [15:0] PLAIN_MIN_LEN = 16'd2;   // length covers opcode bytes
    localparam int          OPCODE_BITS   = 13;      // encrypted opcode, mask 0x1FFF

    typedef struct packed {
        kind_t        kind;
        logic         stream_dir;
        logic [15:0]  opcode;
        logic [18:0]  payload_length;
        logic [7:0]   payload_byte;
        logic         last;
        logic [63:0]  packet_time;
    } res_t;

endpackage

// File: hw/rtl/rc4_header_packet_deframer_top.sv
// rc4_header_packet_deframer_top: RC4-drop keyed packet header deframer.
// Depends on rc4hpd_pkg and rc4hpd_ram (S-box storage).
//
// Usage
//   Input channel (in_valid/in_stall): op 0 starts a session, op 1 carries one
//   stream byte with its capture_time. Output channel (out_valid/out_stall)
//   carries header, payload and framing error transactions, at most one per
//   input transaction. Configuration (cfg_we/cfg_index/cfg_data) loads the
//   20-byte key and the direction tag; write it only while the block is idle.
//
// Sequencing (in_stall is high whenever the sequencer is busy)
//   start:              S-box fill, key schedule, then DROP_BYTES dropped keystream steps
//   payload byte:       result registered at acceptance, output slot loaded from EMIT
//   plain header byte:  shifted into the header; the fourth byte gives the header result
//   encrypted hdr byte: decrypted by a keystream step first; the keystream step does five
//                       accesses to the single S-box RAM (one write port)
//   byte after error:   dropped
// The output register decouples the sides: a new transaction is taken while a
// result waits; a further result waits in EMIT until the output slot frees.
// Reset clears framing and config; the S-box is undefined until a start.
module rc4_header_packet_deframer_top
    import rc4hpd_pkg::*;
#(
    parameter int DROP_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  data_byte,
    input  logic [63:0] capture_time,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic        stream_dir,
    output logic [15:0] opcode,
    output logic [18:0] payload_length,
    output logic [7:0]  payload_byte,
    output logic        last,
    output logic [63:0] packet_time
);

    localparam int  DCW     = $clog2(DROP_BYTES + 2);
    localparam bit  NO_DROP = (DROP_BYTES == 0);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,     // S[n] = n
        ST_K_RD_I,   // key schedule: read S[i]
        ST_K_RD_J,   // j += S[i] + key, read S[j]
        ST_K_WR_I,   // S[i] = S[j]
        ST_K_WR_J,   // S[j] = old S[i]
        ST_P_RD_I,   // keystream: read S[i+1]
        ST_P_RD_J,
        ST_P_WR_I,
        ST_P_WR_J,   // also reads S[S[i]+S[j]]
        ST_P_KS,
        ST_HDR,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [7:0]       i_reg;
    logic [7:0]       j_reg;
    logic [4:0]       kidx_reg;
    logic [DCW-1:0]   drop_cnt_reg;
    logic             drop_reg;
    logic [31:0]      header_shift_reg;
    logic [1:0]       hcount_reg;
    logic [1:0]       plain_left_reg;
    logic [18:0]      payload_left_reg;
    logic             error_reg;
    logic             out_valid_reg;

    logic [63:0]      key_low_reg;
    logic [63:0]      key_mid_reg;
    logic [31:0]      key_high_reg;
    logic             direction_reg;

    // datapath, no reset
    logic [7:0]       byte_reg;
    logic [63:0]      time_reg;
    logic [7:0]       si_reg;
    logic [7:0]       sj_reg;
    logic             fwd_reg;
    res_t             res_reg;
    res_t             out_reg;

    // S-box RAM
    logic             ram_we;
    logic [7:0]       ram_waddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_raddr;
    logic [7:0]       ram_rdata;

    logic             in_accept;
    logic [159:0]     key_vec;
    logic [7:0]       key_b;
    logic [7:0]       ksa_j;
    logic [7:0]       prga_j;
    logic [7:0]       ks_addr;
    logic [7:0]       ks_byte;
    logic [31:0]      shift_new;
    logic [15:0]      plain_len;
    logic             plain_mode;
    logic             plain_short;
    logic [18:0]      enc_len;
    res_t             hdr_res;
    logic             out_free;

    rc4hpd_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_sbox (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign key_vec = {key_high_reg, key_mid_reg, key_low_reg};
    assign key_b   = key_vec[{kidx_reg, 3'b000} +: 8];
    assign ksa_j   = j_reg + ram_rdata + key_b;
    assign prga_j  = j_reg + ram_rdata;
    assign ks_addr = si_reg + sj_reg;
    // same-cycle write to S[j] is not seen by the RAM read
    assign ks_byte = fwd_reg ? si_reg : ram_rdata;

    // S-box access sequencing
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = i_reg;
        ram_wdata = ram_rdata;
        ram_raddr = i_reg;
        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = i_reg;
            end
            ST_K_RD_J: ram_raddr = ksa_j;
            ST_K_WR_I: ram_we = 1'b1;
            ST_K_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
            end
            ST_P_RD_I: ram_raddr = i_reg + 8'd1;
            ST_P_RD_J: ram_raddr = prga_j;
            ST_P_WR_I: ram_we = 1'b1;
            ST_P_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                ram_raddr = ks_addr;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // header assembly and decode
    always_comb
    begin
        shift_new   = header_shift_reg | ({24'd0, byte_reg} << {hcount_reg, 3'b000});
        plain_len   = shift_new[15:0];
        plain_mode  = (plain_left_reg != 2'd0);
        plain_short = (plain_len < PLAIN_MIN_LEN);
        enc_len     = shift_new[31:OPCODE_BITS];

        hdr_res.stream_dir   = direction_reg;
        hdr_res.payload_byte = 8'd0;
        hdr_res.packet_time  = time_reg;
        if (plain_mode)
        begin
            hdr_res.opcode = shift_new[31:16];
            if (plain_short)
            begin
                hdr_res.kind           = KIND_ERROR;
                hdr_res.payload_length = 19'd0;
                hdr_res.last           = 1'b1;
            end
            else
            begin
                hdr_res.kind           = KIND_HEADER;
                hdr_res.payload_length = {3'd0, plain_len - PLAIN_MIN_LEN};
                hdr_res.last           = (plain_len == PLAIN_MIN_LEN);
            end
        end
        else
        begin
            hdr_res.kind           = KIND_HEADER;
            hdr_res.opcode         = {3'd0, shift_new[OPCODE_BITS-1:0]};
            hdr_res.payload_length = enc_len;
            hdr_res.last           = (enc_len == 19'd0);
        end
    end

    // control state and registered output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            i_reg            <= 8'd0;
            j_reg            <= 8'd0;
            kidx_reg         <= 5'd0;
            drop_cnt_reg     <= '0;
            drop_reg         <= 1'b0;
            header_shift_reg <= 32'd0;
            hcount_reg       <= 2'd0;
            plain_left_reg   <= PLAIN_RESET;
            payload_left_reg <= 19'd0;
            error_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            key_low_reg      <= 64'd0;
            key_mid_reg      <= 64'd0;
            key_high_reg     <= 32'd0;
            direction_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_LOW:   key_low_reg   <= cfg_data;
                    CFG_KEY_MID:   key_mid_reg   <= cfg_data;
                    CFG_KEY_HIGH:  key_high_reg  <= cfg_data[31:0];
                    CFG_DIRECTION: direction_reg <= cfg_data[0];
                    default:       direction_reg <= direction_reg;
                endcase
            end

            // output slot: load from EMIT, else drain on acceptance
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (op == OP_START)
                        begin
                            i_reg            <= 8'd0;
                            header_shift_reg <= 32'd0;
                            hcount_reg       <= 2'd0;
                            payload_left_reg <= 19'd0;
                            error_reg        <= 1'b0;
                            plain_left_reg   <= PLAIN_HEADERS;
                            state_reg        <= ST_INIT;
                        end
                        else if (!error_reg)
                        begin
                            if (payload_left_reg != 19'd0)
                            begin
                                payload_left_reg <= payload_left_reg - 19'd1;
                                state_reg        <= ST_EMIT;
                            end
                            else if (plain_left_reg == 2'd0)
                            begin
                                drop_reg  <= 1'b0;
                                state_reg <= ST_P_RD_I;
                            end
                            else
                            begin
                                state_reg <= ST_HDR;
                            end
                        end
                    end
                end
                ST_INIT:
                begin
                    i_reg <= i_reg + 8'd1;
                    if (i_reg == 8'hFF)
                    begin
                        j_reg     <= 8'd0;
                        kidx_reg  <= 5'd0;
                        state_reg <= ST_K_RD_I;
                    end
                end
                ST_K_RD_I: state_reg <= ST_K_RD_J;
                ST_K_RD_J:
                begin
                    j_reg     <= ksa_j;
                    state_reg <= ST_K_WR_I;
                end
                ST_K_WR_I: state_reg <= ST_K_WR_J;
                ST_K_WR_J:
                begin
                    i_reg    <= i_reg + 8'd1;
                    kidx_reg <= (kidx_reg == KEY_LAST) ? 5'd0 : kidx_reg + 5'd1;
                    if (i_reg == 8'hFF)
                    begin
                        // i wraps to zero: keystream indexes start clean
                        j_reg <= 8'd0;
                        if (NO_DROP)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            drop_cnt_reg <= DCW'(DROP_BYTES);
                            drop_reg     <= 1'b1;
                            state_reg    <= ST_P_RD_I;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_K_RD_I;
                    end
                end
                ST_P_RD_I:
                begin
                    i_reg     <= i_reg + 8'd1;
                    state_reg <= ST_P_RD_J;
                end
                ST_P_RD_J:
                begin
                    j_reg     <= prga_j;
                    state_reg <= ST_P_WR_I;
                end
                ST_P_WR_I: state_reg <= ST_P_WR_J;
                ST_P_WR_J: state_reg <= ST_P_KS;
                ST_P_KS:
                begin
                    if (drop_reg)
                    begin
                        drop_cnt_reg <= drop_cnt_reg - DCW'(1);
                        state_reg    <= (drop_cnt_reg == DCW'(1)) ? ST_IDLE : ST_P_RD_I;
                    end
                    else
                    begin
                        state_reg <= ST_HDR;
                    end
                end
                ST_HDR:
                begin
                    if (hcount_reg == 2'd3)
                    begin
                        header_shift_reg <= 32'd0;
                        hcount_reg       <= 2'd0;
                        if (plain_mode)
                        begin
                            plain_left_reg <= plain_left_reg - 2'd1;
                            if (plain_short)
                            begin
                                error_reg <= 1'b1;
                            end
                            else
                            begin
                                payload_left_reg <= {3'd0, plain_len - PLAIN_MIN_LEN};
                            end
                        end
                        else
                        begin
                            payload_left_reg <= enc_len;
                        end
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        header_shift_reg <= shift_new;
                        hcount_reg       <= hcount_reg + 2'd1;
                        state_reg        <= ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= data_byte;
            time_reg <= capture_time;
        end
        if (state_reg == ST_K_RD_J || state_reg == ST_P_RD_J)
        begin
            si_reg <= ram_rdata;
        end
        if (state_reg == ST_P_WR_I)
        begin
            sj_reg <= ram_rdata;
        end
        if (state_reg == ST_P_WR_J)
        begin
            fwd_reg <= (ks_addr == j_reg);
        end
        if (state_reg == ST_P_KS && !drop_reg)
        begin
            byte_reg <= byte_reg ^ ks_byte;
        end

        if (state_reg == ST_IDLE && in_accept && op == OP_BYTE && !error_reg
            && payload_left_reg != 19'd0)
        begin
            res_reg.kind           <= KIND_PAYLOAD;
            res_reg.stream_dir     <= direction_reg;
            res_reg.opcode         <= 16'd0;
            res_reg.payload_length <= 19'd0;
            res_reg.payload_byte   <= data_byte;
            res_reg.last           <= (payload_left_reg == 19'd1);
            res_reg.packet_time    <= capture_time;
        end
        else if (state_reg == ST_HDR)
        begin
            res_reg <= hdr_res;
        end

        if (state_reg == ST_EMIT && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign stream_dir     = out_reg.stream_dir;
    assign opcode         = out_reg.opcode;
    assign payload_length = out_reg.payload_length;
    assign payload_byte   = out_reg.payload_byte;
    assign last           = out_reg.last;
    assign packet_time    = out_reg.packet_time;

`ifndef SYNTHESIS
    // no S-box write outside the sequencer
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_EMIT) |-> !ram_we)
        else $error("S-box written while idle");

    // a payload run only starts with the header fully consumed
    a_payload_clean_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (payload_left_reg != 19'd0) |-> (hcount_reg == 2'd0 && header_shift_reg == 32'd0))
        else $error("payload pending with partial header");

    // sticky error leaves no payload pending
    a_error_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> (payload_left_reg == 19'd0))
        else $error("payload pending after framing error");

    // payload byte goes straight to the result stage
    a_payload_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op == OP_BYTE && !error_reg && payload_left_reg != 19'd0)
        |=> (state_reg == ST_EMIT))
        else $error("payload byte not emitted");

    // a new result only comes from the emit stage
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit");
`endif

endmodule

// File: hw/rtl/rc4hpd_ram.sv
// rc4hpd_ram: generic simple dual-port RAM, one write and one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module rc4hpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: bench/rc4_header_packet_deframer_top_tb.sv
// Self-checking testbench for rc4_header_packet_deframer_top (RC4-drop packet deframer).
// Depends on rc4hpd_pkg and the RTL below it; standalone, with its own keystream and framing model.
`timescale 1ns / 1ps

module rc4_header_packet_deframer_top_tb;
    import rc4hpd_pkg::*;

    localparam int DROP_BYTES  = 1024;
    // a start runs the S-box fill, the key schedule and DROP_BYTES drop steps; settle comfortably beyond that
    localparam int SETTLE      = 7000;
    localparam int LONG_HOLD   = 400;
    // worst case: ~30 starts, ~550 transactions each with the longest gap and stall, settles
    localparam int CYCLE_LIMIT = 1200000;

    // one pending input transaction; cipher asks the driver to encrypt data with the
    // keystream byte the block will use, so random headers still carry short lengths
    typedef struct packed {
        logic        op;
        logic [7:0]  data;
        logic [63:0] stamp;
        logic        cipher;
    } feed_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_KEY_LOW;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = OP_START;
    logic [7:0]  data_byte = '0;
    logic [63:0] capture_time = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic        stream_dir;
    logic [15:0] opcode;
    logic [18:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
    logic [63:0] packet_time;

    rc4_header_packet_deframer_top #(
        .DROP_BYTES(DROP_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .data_byte(data_byte),
        .capture_time(capture_time),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .stream_dir(stream_dir),
        .opcode(opcode),
        .payload_length(payload_length),
        .payload_byte(payload_byte),
        .last(last),
        .packet_time(packet_time)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Deframer model: configuration copy, RC4 state and framing state.
    // The S-box is left at zero until the first start; the stimulus never
    // lets an encrypted header arrive before one.
    // ------------------------------------------------------------------
    logic [63:0] key_lo = '0;
    logic [63:0] key_mi = '0;
    logic [31:0] key_hi = '0;
    logic        dir_tag = 1'b0;

    logic [7:0]  ks_box [256];
    logic [7:0]  ks_x = '0;
    logic [7:0]  ks_y = '0;
    logic [31:0] hdr_word = '0;
    logic [2:0]  hdr_got = '0;
    logic [1:0]  clear_hdrs = PLAIN_RESET;
    logic [18:0] body_left = '0;
    logic        framing_dead = 1'b0;

    res_t  due_results [$];     // header/payload/error transactions still to arrive
    feed_t byte_feed [$];       // input transactions not yet offered
    int    failures = 0;

    initial
    begin
        for (int n = 0; n < 256; n++)
        begin
            ks_box[n] = '0;
        end
    end

    // key byte k of the 20-byte key, repeating every 20 bytes
    function automatic logic [7:0] key_at(input int k);
        int m;
        m = k % 20;
        if (m < 8)
            return key_lo[8 * m +: 8];
        else if (m < 16)
            return key_mi[8 * (m - 8) +: 8];
        return key_hi[8 * (m - 16) +: 8];
    endfunction

    function automatic logic [7:0] keystream_next();
        logic [7:0] t;
        logic [7:0] idx;
        ks_x = ks_x + 8'd1;
        ks_y = ks_y + ks_box[ks_x];
        t = ks_box[ks_x];
        ks_box[ks_x] = ks_box[ks_y];
        ks_box[ks_y] = t;
        idx = ks_box[ks_x] + ks_box[ks_y];
        return ks_box[idx];
    endfunction

    // the next keystream byte, without advancing the generator
    function automatic logic [7:0] keystream_peek();
        logic [7:0] ni, nj, a, b, idx;
        ni = ks_x + 8'd1;
        a = ks_box[ni];
        nj = ks_y + a;
        b = ks_box[nj];
        idx = a + b;
        if (idx == ni)
            return b;
        else if (idx == nj)
            return a;
        return ks_box[idx];
    endfunction

    function automatic void rekey_session();
        logic [7:0] j, t;
        int n;
        for (n = 0; n < 256; n++)
        begin
            ks_box[n] = n[7:0];
        end
        j = '0;
        for (n = 0; n < 256; n++)
        begin
            j = j + ks_box[n] + key_at(n);
            t = ks_box[n];
            ks_box[n] = ks_box[j];
            ks_box[j] = t;
        end
        ks_x = '0;
        ks_y = '0;
        for (n = 0; n < DROP_BYTES; n++)
        begin
            void'(keystream_next());
        end
        hdr_word = '0;
        hdr_got = '0;
        clear_hdrs = PLAIN_HEADERS;
        body_left = '0;
        framing_dead = 1'b0;
    endfunction

    // one accepted input transaction; queues the result it causes, if any
    function automatic void deframe_byte(input logic op_in, input logic [7:0] b_in,
                                         input logic [63:0] stamp);
        res_t        r;
        logic [7:0]  b;
        logic [31:0] w;
        logic [18:0] n;
        b = b_in;
        if (op_in == OP_START)
        begin
            rekey_session();
            return;
        end
        if (framing_dead)
            return;
        r = '0;
        r.stream_dir = dir_tag;
        r.packet_time = stamp;
        if (body_left != 0)
        begin
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            r.last = (body_left == 19'd1);
            body_left = body_left - 19'd1;
            due_results.push_back(r);
            return;
        end
        if (clear_hdrs == 0)
            b = b ^ keystream_next();
        hdr_word = hdr_word | (32'(b) << (8 * hdr_got[1:0]));
        hdr_got = hdr_got + 3'd1;
        if (hdr_got < 3'd4)
            return;
        w = hdr_word;
        hdr_word = '0;
        hdr_got = '0;
        if (clear_hdrs != 0)
        begin
            // plain: length (counting the opcode bytes) then opcode, both 16-bit
            clear_hdrs = clear_hdrs - 2'd1;
            r.opcode = w[31:16];
            if (w[15:0] < PLAIN_MIN_LEN)
            begin
                framing_dead = 1'b1;
                r.kind = KIND_ERROR;
                r.last = 1'b1;
                due_results.push_back(r);
                return;
            end
            n = 19'(w[15:0] - PLAIN_MIN_LEN);
        end
        else
        begin
            // encrypted: 13-bit opcode low, 19-bit length high
            r.opcode = {3'b000, w[12:0]};
            n = w[31:13];
        end
        r.kind = KIND_HEADER;
        r.payload_length = n;
        r.last = (n == 0);
        body_left = n;
        due_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued transactions, runs the model on each accepted
    // one. Gaps mostly short, a few long, with stretches of back-to-back
    // traffic.
    // ------------------------------------------------------------------
    int tx_gap = 0;
    int tx_calm = 0;

    function automatic int pick_gap();
        int roll;
        if (tx_calm > 0)
        begin
            tx_calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            tx_calm = $urandom_range(30, 80);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    always @(posedge clk)
    begin : tx_drive
        feed_t nxt;
        logic  took;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                deframe_byte(op, data_byte, capture_time);
                tx_gap = pick_gap();
            end
            if (took || !in_valid)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (byte_feed.size() != 0)
                begin
                    nxt = byte_feed.pop_front();
                    // encrypt only where the block will really decrypt this byte
                    if (nxt.cipher && !framing_dead && body_left == 0 && clear_hdrs == 0)
                        nxt.data = nxt.data ^ keystream_peek();
                    in_valid <= 1'b1;
                    op <= nxt.op;
                    data_byte <= nxt.data;
                    capture_time <= nxt.stamp;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver pacing: random stalls, calm stretches, and once a long
    // hold-off so that the output slot and the input side back up.
    // ------------------------------------------------------------------
    int   rx_hold = 0;
    int   rx_calm = 0;
    int   rx_taken = 0;
    logic long_hold_done = 1'b0;

    always @(posedge clk)
    begin : rx_pace
        int roll;
        if (rx_hold > 0)
        begin
            rx_hold--;
        end
        else if (!long_hold_done && rx_taken >= 150)
        begin
            long_hold_done = 1'b1;
            rx_hold = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (rx_calm > 0)
        begin
            rx_calm--;
            out_stall <= 1'b0;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                rx_calm = $urandom_range(40, 150);
                out_stall <= 1'b0;
            end
            else if (roll < 70)
            begin
                out_stall <= 1'b0;
            end
            else if (roll < 96)
            begin
                out_stall <= 1'b1;
                rx_hold = $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                rx_hold = $urandom_range(10, 40);
            end
        end
        if (out_valid && !out_stall)
            rx_taken++;
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d opcode %0h",
                         $time, kind, opcode);
                failures++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("kind", want.kind, kind);
                check_field("stream_dir", want.stream_dir, stream_dir);
                check_field("opcode", want.opcode, opcode);
                check_field("payload_length", want.payload_length, payload_length);
                check_field("payload_byte", want.payload_byte, payload_byte);
                check_field("last", want.last, last);
                check_field("packet_time", want.packet_time, packet_time);
            end
        end
    end

    // watchdog
    int cycles = 0;

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation. gen_plain tracks plain headers left in the
    // session being built; gen_dead marks bytes the block will drop after
    // a framing error, which do not count as stimulus.
    // ------------------------------------------------------------------
    int   gen_plain = 0;
    logic gen_dead = 1'b0;
    int   stim_items = 0;

    function automatic logic [63:0] rand_stamp();
        return {$urandom, $urandom};
    endfunction

    task automatic offer(input logic op_in, input logic [7:0] d, input logic c,
                         input logic [63:0] s);
        feed_t f;
        f.op = op_in;
        f.data = d;
        f.stamp = s;
        f.cipher = c;
        byte_feed.push_back(f);
        if (!gen_dead)
            stim_items++;
    endtask

    task automatic queue_start();
        gen_dead = 1'b0;
        gen_plain = PLAIN_HEADERS;
        offer(OP_START, 8'($urandom), 1'b0, rand_stamp());
    endtask

    task automatic queue_plain(input logic [15:0] len, input logic [15:0] opc, input int nbody);
        offer(OP_BYTE, len[7:0], 1'b0, rand_stamp());
        offer(OP_BYTE, len[15:8], 1'b0, rand_stamp());
        offer(OP_BYTE, opc[7:0], 1'b0, rand_stamp());
        offer(OP_BYTE, opc[15:8], 1'b0, rand_stamp());
        if (len < PLAIN_MIN_LEN)
            gen_dead = 1'b1;
        gen_plain--;
        repeat (nbody) offer(OP_BYTE, 8'($urandom), 1'b0, rand_stamp());
    endtask

    task automatic queue_sealed(input logic [12:0] opc, input logic [18:0] len, input int nbody);
        logic [31:0] w;
        w = {len, opc};
        for (int k = 0; k < 4; k++)
        begin
            offer(OP_BYTE, w[8 * k +: 8], 1'b1, rand_stamp());
        end
        repeat (nbody) offer(OP_BYTE, 8'($urandom), 1'b0, rand_stamp());
    endtask

    // one session: mostly well-formed packets, sometimes cut off by a
    // framing error, an oversized header or a truncated header
    task automatic queue_session(input int quota);
        int roll, nbody, stop_at;
        queue_start();
        stop_at = stim_items + quota;
        while (stim_items < stop_at)
        begin
            roll = $urandom_range(0, 99);
            nbody = (roll >= 95) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            if (roll < 3 && gen_plain > 0)
            begin
                // plain length too short for the opcode; trailing bytes are dropped
                queue_plain(16'($urandom_range(0, 1)), 16'($urandom), 0);
                repeat ($urandom_range(1, 3)) offer(OP_BYTE, 8'($urandom), 1'b0, rand_stamp());
                return;
            end
            if (roll < 6)
            begin
                // huge payload length, abandoned by the next start
                if (gen_plain > 0)
                    queue_plain(16'($urandom_range(9, 65535)), 16'($urandom),
                                $urandom_range(0, 3));
                else
                    queue_sealed(13'($urandom), (roll == 5) ? 19'h7FFFF : 19'($urandom),
                                 $urandom_range(0, 3));
                return;
            end
            if (roll < 8)
            begin
                // header cut short by a start
                repeat ($urandom_range(1, 3))
                    offer(OP_BYTE, 8'($urandom), gen_plain == 0, rand_stamp());
                return;
            end
            if (gen_plain > 0)
                queue_plain(16'(nbody + 2), 16'($urandom), nbody);
            else
                queue_sealed(13'($urandom), 19'(nbody), nbody);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_KEY_LOW:   key_lo = val;
            CFG_KEY_MID:   key_mi = val;
            CFG_KEY_HIGH:  key_hi = val[31:0];
            CFG_DIRECTION: dir_tag = val[0];
            default:       ;
        endcase
    endtask

    // junk above the narrow registers checks that it is ignored
    task automatic program_keys(input logic [63:0] lo, input logic [63:0] mi,
                                input logic [31:0] hi, input logic d);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_KEY_LOW, lo);
        write_reg(CFG_KEY_MID, mi);
        write_reg(CFG_KEY_HIGH, {junk[63:32], hi});
        write_reg(CFG_DIRECTION, {junk[63:1], d});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // everything offered, accepted and answered, then room for a trailing start
    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_feed.size() != 0 || in_valid || due_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int ph, goal;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // before any start: one plain packet in the reset state, opcode all ones,
        // stamps at both extremes
        gen_plain = PLAIN_RESET;
        offer(OP_BYTE, 8'h03, 1'b0, 64'd0);
        offer(OP_BYTE, 8'h00, 1'b0, 64'd0);
        offer(OP_BYTE, 8'hFF, 1'b0, '1);
        offer(OP_BYTE, 8'hFF, 1'b0, '1);
        offer(OP_BYTE, 8'hFF, 1'b0, '1);
        // zero plain length: error, then a dropped byte
        queue_start();
        queue_plain(16'd0, 16'h5A5A, 0);
        offer(OP_BYTE, 8'hAA, 1'b0, rand_stamp());
        // fresh session through both plain headers into the first encrypted one
        queue_start();
        queue_plain(16'd2, 16'h0001, 0);
        queue_plain(16'd2, 16'h8000, 0);
        queue_sealed(13'h1FFF, 19'd0, 0);
        wait_idle();

        // random phases, each under its own key and direction
        goal = stim_items;
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       program_keys('1, '1, '1, 1'b1);
                1:       program_keys('0, '0, '0, 1'b0);
                default: program_keys({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                                      ph[0]);
            endcase
            @(negedge clk);
            goal = goal + 75;
            while (stim_items < goal)
            begin
                queue_session($urandom_range(20, 60));
            end
            wait_idle();
        end

        if (failures == 0 && due_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rc4hpd_pkg.sv
hw/rtl/rc4hpd_ram.sv
hw/rtl/rc4_header_packet_deframer_top.sv
bench/rc4_header_packet_deframer_top_tb.sv
